@@ design/assert_macros.svh @@
// assertion macros, included by the session reverse lookup table design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ design/srlt_pkg.sv @@
// types and constants of the session reverse lookup table
package srlt_pkg;

    localparam int SESSION_W = 10;
    localparam int IP_W      = 32;
    localparam int PORT_W    = 16;

    localparam logic [1:0] REQ_INSERT  = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP  = 2'd2;

    localparam logic REPLY_RELEASE = 1'b0;
    localparam logic REPLY_LOOKUP  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic [IP_W-1:0]   local_ip;
        logic [IP_W-1:0]   remote_ip;
        logic [PORT_W-1:0] local_port;
        logic [PORT_W-1:0] remote_port;
    } t_tuple;

    typedef struct packed {
        logic rd_en;
        logic tup_we;
        logic vld_we;
        logic vld_wdata;
    } t_store_ctl;

endpackage

@@ design/srlt_store.sv @@
// tuple memory and valid-bit memory, one shared address, registered reads
module srlt_store import srlt_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int IDX_W = 10
) (
    input  logic             i_clk,
    input  t_store_ctl       i_ctl,
    input  logic [IDX_W-1:0] i_addr,
    input  t_tuple           i_wr_tuple,
    output t_tuple           o_rd_tuple,
    output logic             o_rd_valid
);

    t_tuple r_tuple_mem [DEPTH];
    logic   r_valid_mem [DEPTH];
    t_tuple r_rd_tuple;
    logic   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.tup_we) begin
            r_tuple_mem[i_addr] <= i_wr_tuple;
        end
        if (i_ctl.rd_en) begin
            r_rd_tuple <= r_tuple_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld_we) begin
            r_valid_mem[i_addr] <= i_ctl.vld_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rd_valid <= r_valid_mem[i_addr];
        end
    end

    assign o_rd_tuple = r_rd_tuple;
    assign o_rd_valid = r_rd_valid;

endmodule

@@ design/session_reverse_lookup_table.sv @@
// session reverse lookup table: session number to stored four-tuple, with valid bits
// an insert is written when it is taken; a release or lookup reads the memory, and its reply strobes
// in the cycle after the memory read, while the next request may already be taken
// the rate is set by the single address port shared by reads and write-backs
// after reset, busy stays high while the valid bits of all sessions are cleared
`include "assert_macros.svh"

module session_reverse_lookup_table import srlt_pkg::*; #(
    parameter int SESSION_COUNT = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_req_type,
    input  logic [SESSION_W-1:0] i_session_id,
    input  logic [IP_W-1:0]      i_local_ip,
    input  logic [IP_W-1:0]      i_remote_ip,
    input  logic [PORT_W-1:0]    i_local_port,
    input  logic [PORT_W-1:0]    i_remote_port,
    output logic                 strobe,
    output logic                 o_reply_kind,
    output logic [SESSION_W-1:0] o_reply_session,
    output logic [IP_W-1:0]      o_out_local_ip,
    output logic [IP_W-1:0]      o_out_remote_ip,
    output logic [PORT_W-1:0]    o_out_local_port,
    output logic [PORT_W-1:0]    o_out_remote_port
);

    localparam int IDX_W = $clog2(SESSION_COUNT);

    t_state             r_state;
    t_state             n_state;
    logic [IDX_W-1:0]   r_clr_cnt;
    logic [IDX_W-1:0]   n_clr_cnt;

    logic               w_accept;
    logic               w_in_range;
    logic [IDX_W-1:0]   w_idx;
    logic               w_clr_last;

    logic               r_release;
    logic               r_in_range;
    logic [SESSION_W-1:0] r_sess;
    logic [IDX_W-1:0]   r_idx;

    t_store_ctl         w_ctl;
    logic [IDX_W-1:0]   w_addr;
    t_tuple             w_wr_tuple;
    t_tuple             w_rd_tuple;
    logic               w_rd_valid;

    logic               r_strobe;
    logic               n_strobe;
    logic               r_reply_kind;
    logic [SESSION_W-1:0] r_reply_session;
    t_tuple             r_out_tuple;
    t_tuple             n_out_tuple;

    assign w_accept   = start && !busy;
    assign w_in_range = 32'(i_session_id) < 32'(SESSION_COUNT);
    assign w_idx      = IDX_W'(i_session_id);
    assign w_clr_last = r_clr_cnt == IDX_W'(SESSION_COUNT - 1);

    assign w_wr_tuple.local_ip    = i_local_ip;
    assign w_wr_tuple.remote_ip   = i_remote_ip;
    assign w_wr_tuple.local_port  = i_local_port;
    assign w_wr_tuple.remote_port = i_remote_port;

    srlt_store #(
        .DEPTH (SESSION_COUNT),
        .IDX_W (IDX_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_addr     (w_addr),
        .i_wr_tuple (w_wr_tuple),
        .o_rd_tuple (w_rd_tuple),
        .o_rd_valid (w_rd_valid)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept && (i_req_type inside {REQ_RELEASE, REQ_LOOKUP})) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // outputs and memory control
    always_comb begin
        busy        = 1'b0;
        w_ctl       = '0;
        w_addr      = w_idx;
        n_clr_cnt   = r_clr_cnt;
        n_strobe    = 1'b0;
        n_out_tuple = '0;
        case (r_state)
            ST_CLEAR: begin
                busy            = 1'b1;
                w_ctl.vld_we    = 1'b1;
                w_ctl.vld_wdata = 1'b0;
                w_addr          = r_clr_cnt;
                n_clr_cnt       = r_clr_cnt + 1'b1;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    w_ctl.rd_en = 1'b1;
                    if (i_req_type == REQ_INSERT && w_in_range) begin
                        w_ctl.tup_we    = 1'b1;
                        w_ctl.vld_we    = 1'b1;
                        w_ctl.vld_wdata = 1'b1;
                    end
                end
            end
            ST_READ: begin
                busy   = 1'b1;
                w_addr = r_idx;
                if (r_in_range) begin
                    n_out_tuple = w_rd_tuple;
                end
                if (r_release) begin
                    n_strobe = r_in_range && w_rd_valid;
                    if (r_in_range && w_rd_valid) begin
                        w_ctl.vld_we    = 1'b1;
                        w_ctl.vld_wdata = 1'b0;
                    end
                end else begin
                    n_strobe = 1'b1;
                end
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_strobe  <= n_strobe;
        end
    end

    // request held over the read cycle, reply payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_release  <= i_req_type == REQ_RELEASE;
            r_in_range <= w_in_range;
            r_sess     <= i_session_id;
            r_idx      <= w_idx;
        end
        if (r_state == ST_READ) begin
            r_reply_kind    <= r_release ? REPLY_RELEASE : REPLY_LOOKUP;
            r_out_tuple     <= n_out_tuple;
            r_reply_session <= r_sess;
        end
    end

    assign strobe            = r_strobe;
    assign o_reply_kind      = r_reply_kind;
    assign o_reply_session   = r_reply_session;
    assign o_out_local_ip    = r_out_tuple.local_ip;
    assign o_out_remote_ip   = r_out_tuple.remote_ip;
    assign o_out_local_port  = r_out_tuple.local_port;
    assign o_out_remote_port = r_out_tuple.remote_port;

    `ASSERT_IMPLY(a_strobe_after_read, i_clk, i_rst_n, strobe, $past(r_state == ST_READ))
    `ASSERT_IMPLY(a_read_after_accept, i_clk, i_rst_n, r_state == ST_READ, $past(start && !busy))
    `ASSERT_NEXT(a_strobe_gap, i_clk, i_rst_n, strobe, !strobe)
    `ASSERT_NEXT(a_accept_no_strobe, i_clk, i_rst_n, start && !busy, !strobe)

endmodule

@@ bench/srlt_checker.sv @@
// checker for the session reverse lookup table: watches transfers, predicts replies, compares
`timescale 1ns / 1ps

module srlt_checker import srlt_pkg::*; #(
    parameter int SESSION_COUNT = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [1:0]           i_req_type,
    input  logic [SESSION_W-1:0] i_session_id,
    input  logic [IP_W-1:0]      i_local_ip,
    input  logic [IP_W-1:0]      i_remote_ip,
    input  logic [PORT_W-1:0]    i_local_port,
    input  logic [PORT_W-1:0]    i_remote_port,
    input  logic                 i_strobe,
    input  logic                 i_reply_kind,
    input  logic [SESSION_W-1:0] i_reply_session,
    input  logic [IP_W-1:0]      i_out_local_ip,
    input  logic [IP_W-1:0]      i_out_remote_ip,
    input  logic [PORT_W-1:0]    i_out_local_port,
    input  logic [PORT_W-1:0]    i_out_remote_port,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic                 kind;
        logic [SESSION_W-1:0] session;
        t_tuple               tup;
    } t_reply;

    t_tuple stored_tuples [SESSION_COUNT];
    logic   entry_live    [SESSION_COUNT];
    t_reply awaited_replies[$];
    int     fails = 0;

    task automatic check_field(input string name, input logic [IP_W-1:0] want,
                               input logic [IP_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            fails++;
        end
    endtask

    task automatic compare_reply();
        t_reply want;
        if (awaited_replies.size() == 0) begin
            $display("%0t: reply expected none actual kind %b session %0d", $time,
                     i_reply_kind, i_reply_session);
            fails++;
        end else begin
            want = awaited_replies.pop_front();
            check_field("reply_kind", IP_W'(want.kind), IP_W'(i_reply_kind));
            check_field("reply_session", IP_W'(want.session), IP_W'(i_reply_session));
            check_field("out_local_ip", want.tup.local_ip, i_out_local_ip);
            check_field("out_remote_ip", want.tup.remote_ip, i_out_remote_ip);
            check_field("out_local_port", IP_W'(want.tup.local_port),
                        IP_W'(i_out_local_port));
            check_field("out_remote_port", IP_W'(want.tup.remote_port),
                        IP_W'(i_out_remote_port));
        end
    endtask

    task automatic predict_transfer();
        t_reply reply;
        logic   in_range;
        in_range = i_session_id < SESSION_COUNT;
        case (i_req_type)
            REQ_INSERT: begin
                if (in_range) begin
                    stored_tuples[i_session_id] = '{i_local_ip, i_remote_ip,
                                                    i_local_port, i_remote_port};
                    entry_live[i_session_id] = 1'b1;
                end
            end
            REQ_RELEASE: begin
                if (in_range && entry_live[i_session_id]) begin
                    reply.kind    = REPLY_RELEASE;
                    reply.session = i_session_id;
                    reply.tup     = stored_tuples[i_session_id];
                    awaited_replies.push_back(reply);
                    entry_live[i_session_id] = 1'b0;
                end
            end
            REQ_LOOKUP: begin
                reply.kind    = REPLY_LOOKUP;
                reply.session = i_session_id;
                reply.tup     = in_range ? stored_tuples[i_session_id] : '0;
                awaited_replies.push_back(reply);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (entry_live[i]) entry_live[i] = 1'b0;
            awaited_replies.delete();
        end else begin
            if (i_strobe !== 1'b0) compare_reply();
            if (i_start && !i_busy) predict_transfer();
        end
        o_pending    <= awaited_replies.size();
        o_fail_count <= fails;
    end

endmodule

@@ bench/tb_top.sv @@
// testbench top for the session reverse lookup table: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_top import srlt_pkg::*;;

    localparam int         SESSIONS     = 1024;
    localparam int         ITEM_TARGET  = 600;
    localparam int         STALL_LIMIT  = 5000;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           i_req_type = REQ_INSERT;
    logic [SESSION_W-1:0] i_session_id = '0;
    logic [IP_W-1:0]      i_local_ip = '0;
    logic [IP_W-1:0]      i_remote_ip = '0;
    logic [PORT_W-1:0]    i_local_port = '0;
    logic [PORT_W-1:0]    i_remote_port = '0;
    logic                 strobe;
    logic                 o_reply_kind;
    logic [SESSION_W-1:0] o_reply_session;
    logic [IP_W-1:0]      o_out_local_ip;
    logic [IP_W-1:0]      o_out_remote_ip;
    logic [PORT_W-1:0]    o_out_local_port;
    logic [PORT_W-1:0]    o_out_remote_port;
    int                   fail_count;
    int                   pending;
    int                   idle_cycles = 0;
    bit                   session_written [SESSIONS];

    always #10 i_clk = ~i_clk;

    session_reverse_lookup_table #(.SESSION_COUNT(SESSIONS)) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_req_type        (i_req_type),
        .i_session_id      (i_session_id),
        .i_local_ip        (i_local_ip),
        .i_remote_ip       (i_remote_ip),
        .i_local_port      (i_local_port),
        .i_remote_port     (i_remote_port),
        .strobe            (strobe),
        .o_reply_kind      (o_reply_kind),
        .o_reply_session   (o_reply_session),
        .o_out_local_ip    (o_out_local_ip),
        .o_out_remote_ip   (o_out_remote_ip),
        .o_out_local_port  (o_out_local_port),
        .o_out_remote_port (o_out_remote_port)
    );

    srlt_checker #(.SESSION_COUNT(SESSIONS)) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_req_type        (i_req_type),
        .i_session_id      (i_session_id),
        .i_local_ip        (i_local_ip),
        .i_remote_ip       (i_remote_ip),
        .i_local_port      (i_local_port),
        .i_remote_port     (i_remote_port),
        .i_strobe          (strobe),
        .i_reply_kind      (o_reply_kind),
        .i_reply_session   (o_reply_session),
        .i_out_local_ip    (o_out_local_ip),
        .i_out_remote_ip   (o_out_remote_ip),
        .i_out_local_port  (o_out_local_port),
        .i_out_remote_port (o_out_remote_port),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((start && !busy) || strobe === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("session_reverse_lookup_table: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(input logic [1:0] req, input logic [SESSION_W-1:0] sess,
                        input logic [IP_W-1:0] lip, input logic [IP_W-1:0] rip,
                        input logic [PORT_W-1:0] lport, input logic [PORT_W-1:0] rport);
        @(negedge i_clk);
        start         <= 1'b1;
        i_req_type    <= req;
        i_session_id  <= sess;
        i_local_ip    <= lip;
        i_remote_ip   <= rip;
        i_local_port  <= lport;
        i_remote_port <= rport;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (req == REQ_INSERT) session_written[sess] = 1'b1;
    endtask

    task automatic pause(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic send_random(output bit counted);
        logic [1:0]           req;
        logic [SESSION_W-1:0] sess;
        int                   pick;
        pick    = $urandom_range(0, 99);
        sess    = ($urandom_range(0, 9) < 7) ? SESSION_W'($urandom_range(0, 31))
                                             : SESSION_W'($urandom_range(0, SESSIONS - 1));
        counted = 1'b1;
        if (pick < 40)      req = REQ_INSERT;
        else if (pick < 65) req = REQ_RELEASE;
        else if (pick < 93) req = session_written[sess] ? REQ_LOOKUP : REQ_INSERT;
        else begin
            req     = REQ_UNUSED;
            counted = 1'b0;
        end
        send(req, sess, $urandom, $urandom, PORT_W'($urandom_range(0, 65535)),
             PORT_W'($urandom_range(0, 65535)));
    endtask

    initial begin
        int sent;
        int burst;
        bit counted;
        sent = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        send(REQ_INSERT, 10'd0, 32'h0, 32'h0, 16'h0, 16'h0);
        send(REQ_INSERT, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send(REQ_LOOKUP, 10'd0, '1, '1, '1, '1);
        send(REQ_LOOKUP, 10'd1023, '0, '0, '0, '0);
        send(REQ_RELEASE, 10'd0, '0, '0, '0, '0);
        send(REQ_RELEASE, 10'd0, '0, '0, '0, '0);
        send(REQ_LOOKUP, 10'd0, '0, '0, '0, '0);
        send(REQ_INSERT, 10'h155, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'hA5A5, 16'h5A5A);
        send(REQ_RELEASE, 10'd1023, '0, '0, '0, '0);
        send(REQ_LOOKUP, 10'd1023, '0, '0, '0, '0);
        send(REQ_UNUSED, 10'h155, '1, '1, '1, '1);
        send(REQ_LOOKUP, 10'h155, '0, '0, '0, '0);
        send(REQ_INSERT, 10'h2AA, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 16'h5A5A, 16'hA5A5);
        send(REQ_RELEASE, 10'h2AA, '0, '0, '0, '0);
        send(REQ_LOOKUP, 10'h2AA, '0, '0, '0, '0);
        send(REQ_RELEASE, 10'd700, '0, '0, '0, '0);
        send(REQ_INSERT, 10'd512, 32'h8000_0001, 32'h0000_0001, 16'h8000, 16'h0001);
        send(REQ_LOOKUP, 10'd512, '0, '0, '0, '0);
        send(REQ_RELEASE, 10'd512, '0, '0, '0, '0);
        send(REQ_INSERT, 10'd512, 32'h7FFF_FFFE, 32'hFFFF_FFFE, 16'h7FFF, 16'hFFFE);
        pause(3);
        send(REQ_RELEASE, 10'd512, '0, '0, '0, '0);
        send(REQ_LOOKUP, 10'd512, '0, '0, '0, '0);
        send(REQ_INSERT, 10'h155, 32'h1234_5678, 32'h9ABC_DEF0, 16'h1357, 16'h2468);
        send(REQ_RELEASE, 10'h155, '0, '0, '0, '0);

        // random part in bursts
        while (sent < ITEM_TARGET) begin
            burst = $urandom_range(1, 20);
            repeat (burst) begin
                send_random(counted);
                if (counted) sent++;
            end
            if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
        end

        pause(1);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("session_reverse_lookup_table: match");
        end else begin
            $display("session_reverse_lookup_table: mismatch");
        end
        $finish;
    end

endmodule
